FILE: hw/rtl/cia_pkg.sv
`default_nettype none

package cia_pkg;

    // Defaults and fixed limits.
    localparam int MAX_COMPONENTS_DEF = 8;
    localparam int MAX_BASIS = 32;
    localparam int MAX_DIMS = 6;

    // Component index wide enough for the largest component count.
    localparam int IDX_W = 7;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE           = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BASIS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COMPONENTS = 2'd2;

    localparam logic [1:0] MODE_RST           = 2'd0;
    localparam logic [5:0] NUM_BASIS_RST      = 6'd1;
    localparam logic [3:0] NUM_COMPONENTS_RST = 4'd1;

    // Item kinds.
    localparam logic [1:0] KIND_WIDTH = 2'd0;
    localparam logic [1:0] KIND_COEF  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Modes.
    localparam logic [1:0] MODE_VALUE    = 2'd0;
    localparam logic [1:0] MODE_ABS      = 2'd1;
    localparam logic [1:0] MODE_SQUARE   = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // Fixed-point constants.
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
    localparam logic [47:0] VOL_ONE       = 48'h0001_0000_0000;
    localparam logic [63:0] VOL_MAX       = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN       = 64'h8000_0000_0000_0000;

    // Shared multiplier geometry.
    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 48;
    localparam int CHUNK_W  = 16;
    localparam int N_CHUNKS = MUL_B_W / CHUNK_W;
    localparam int PP_W     = MUL_A_W + CHUNK_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ACC_W    = 64;

    // Multiplier passes.
    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_VOL  = 3'd1,
        OP_SQ   = 3'd2,
        OP_AMT1 = 3'd3,
        OP_AMT2 = 3'd4
    } t_op;

    typedef struct packed {
        logic load_item;
        logic load_wshift;
        logic rd_acc;
        logic mul_start;
        logic mul_step;
        logic round;
        logic vol_set;
        logic acc_write;
        logic clear;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       width_ok;
        logic       use_norm;
        logic       dim_zero;
        logic       coef_ok;
        logic       mode_sq;
        logic       mul_last;
        logic       out_busy;
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/cia_in_if.sv
`default_nettype none

interface cia_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic        [2:0]  dim_index;
    logic        [31:0] width;
    logic        [2:0]  component;
    logic        [4:0]  basis_index;
    logic signed [31:0] coefficient;

    modport source (
        output valid, kind, dim_index, width, component, basis_index, coefficient,
        input  ready
    );

    modport sink (
        input  valid, kind, dim_index, width, component, basis_index, coefficient,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/cia_out_if.sv
`default_nettype none

interface cia_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  read_component;
    logic signed [63:0] total;
    logic               saturated;

    modport source (
        output valid, read_component, total, saturated,
        input  ready
    );

    modport sink (
        input  valid, read_component, total, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/cia_ram.sv
`default_nettype none

module cia_ram #(
    parameter  int WIDTH = 65,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hw/rtl/cia_ctrl.sv
`default_nettype none

module cia_ctrl import cia_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_RND    = 8'b0001_0000,
        S_VSET   = 8'b0010_0000,
        S_ACC    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                // The accumulator read is issued for every item; only reads and
                // coefficients look at the data.
                o_cmd.rd_acc      = 1'b1;
                o_cmd.load_wshift = 1'b1;
                unique case (i_status.kind)
                    KIND_WIDTH: begin
                        if (!i_status.width_ok) begin
                            n_state = S_IDLE;
                        end else if (i_status.use_norm) begin
                            n_op    = OP_NORM;
                            n_state = S_LOAD;
                        end else if (i_status.dim_zero) begin
                            n_state = S_VSET;
                        end else begin
                            n_op    = OP_VOL;
                            n_state = S_LOAD;
                        end
                    end
                    KIND_COEF: begin
                        if (!i_status.coef_ok) begin
                            n_state = S_IDLE;
                        end else if (i_status.mode_sq) begin
                            n_op    = OP_SQ;
                            n_state = S_LOAD;
                        end else begin
                            n_op    = OP_AMT1;
                            n_state = S_LOAD;
                        end
                    end
                    KIND_READ: begin
                        n_state = S_OUT;
                    end
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LOAD: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.round = 1'b1;
                unique case (r_op)
                    OP_NORM: begin
                        if (i_status.dim_zero) begin
                            n_state = S_VSET;
                        end else begin
                            n_op    = OP_VOL;
                            n_state = S_LOAD;
                        end
                    end
                    OP_VOL: n_state = S_VSET;
                    OP_SQ: begin
                        n_op    = OP_AMT2;
                        n_state = S_LOAD;
                    end
                    OP_AMT1, OP_AMT2: n_state = S_ACC;
                    default: n_state = S_IDLE;
                endcase
            end
            S_VSET: begin
                o_cmd.vol_set = 1'b1;
                n_state = S_IDLE;
            end
            S_ACC: begin
                o_cmd.acc_write = 1'b1;
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NORM;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cia_datapath.sv
`default_nettype none

module cia_datapath import cia_pkg::*; #(
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]             i_kind,
    input  logic [2:0]             i_dim_index,
    input  logic [31:0]            i_width,
    input  logic [2:0]             i_component,
    input  logic [4:0]             i_basis_index,
    input  logic signed [31:0]     i_coefficient,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_read_component,
    output logic signed [63:0]     o_total,
    output logic                   o_saturated,
    input  t_cmd                   i_cmd,
    output t_status                o_status
);

    localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int RAM_W = ACC_W + 1;
    localparam logic [SUM_W-1:0] RND_16 = SUM_W'(1) << 15;
    localparam logic [SUM_W-1:0] RND_32 = SUM_W'(1) << 31;

    // Configuration.
    logic [1:0] r_mode;
    logic [5:0] r_num_basis;
    logic [3:0] r_num_comp;

    // Current item.
    logic [1:0]  r_kind;
    logic [2:0]  r_dim;
    logic [31:0] r_width;
    logic [2:0]  r_comp;
    logic [4:0]  r_basis;
    logic [31:0] r_coef;

    // Arithmetic state.
    logic [47:0]        r_vol;
    logic [63:0]        r_res;
    logic               r_sat;
    logic [MUL_A_W-1:0] r_mul_a;
    logic [MUL_B_W-1:0] r_mul_b;
    logic [1:0]         r_k;
    logic [PROD_W-1:0]  r_prod;

    logic [MAX_COMPONENTS-1:0] r_valid;

    logic               r_out_valid;
    logic [2:0]         r_out_comp;
    logic [ACC_W-1:0]   r_out_total;
    logic               r_out_sat;

    logic [IDX_W-1:0]   comp_wide;
    logic               comp_in_range;
    logic [AW-1:0]      addr;
    logic               normalize;
    logic [31:0]        mag;
    logic [47:0]        w_shift;
    logic [CHUNK_W-1:0] chunk;
    logic [PP_W-1:0]    pp;
    logic [PROD_W-1:0]  pp_shifted;
    logic [MUL_A_W-1:0] n_mul_a;
    logic [MUL_B_W-1:0] n_mul_b;
    logic [SUM_W-1:0]   sum_rnd;
    logic [SUM_W-1:0]   q;
    logic [63:0]        limit;
    logic               rnd_sat;
    logic [RAM_W-1:0]   ram_rd;
    logic               old_valid;
    logic [ACC_W-1:0]   old_acc;
    logic               old_mark;
    logic [ACC_W-1:0]   amt;
    logic [ACC_W-1:0]   acc_sum;
    logic               acc_ovf;
    logic [ACC_W-1:0]   acc_new;

    // Item decode.
    assign comp_wide     = IDX_W'(r_comp);
    assign comp_in_range = comp_wide < IDX_W'(MAX_COMPONENTS);
    assign addr          = comp_wide[AW-1:0];
    assign normalize     = r_num_basis > 6'd1;
    assign mag           = r_coef[31] ? (~r_coef + 32'd1) : r_coef;
    assign w_shift       = normalize ? {1'b0, r_width, 15'd0} : {r_width, 16'd0};

    assign o_status.kind     = r_kind;
    assign o_status.width_ok = {1'b0, r_dim} < 4'(MAX_DIMS);
    assign o_status.use_norm = normalize && (r_mode == MODE_VALUE || r_mode == MODE_ABS);
    assign o_status.dim_zero = r_dim == 3'd0;
    assign o_status.coef_ok  = ({1'b0, r_comp} < r_num_comp) && comp_in_range
                            && ({1'b0, r_basis} < r_num_basis)
                            && ({2'b0, r_basis} < 7'(MAX_BASIS))
                            && (r_mode != MODE_RESERVED)
                            && (r_mode == MODE_SQUARE || r_basis == 5'd0);
    assign o_status.mode_sq  = r_mode == MODE_SQUARE;
    assign o_status.mul_last = r_k == 2'(N_CHUNKS - 1);
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // Operand selection for the next multiplier pass.
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        unique case (i_cmd.op)
            OP_NORM: begin
                n_mul_a = MUL_A_W'(r_width);
                n_mul_b = MUL_B_W'(INV_SQRT2_Q32);
            end
            OP_VOL: begin
                n_mul_a = MUL_A_W'(r_vol);
                n_mul_b = r_res[MUL_B_W-1:0];
            end
            OP_SQ: begin
                n_mul_a = MUL_A_W'(mag);
                n_mul_b = MUL_B_W'(mag);
            end
            OP_AMT1: begin
                n_mul_a = MUL_A_W'(mag);
                n_mul_b = r_vol;
            end
            OP_AMT2: begin
                n_mul_a = r_res;
                n_mul_b = r_vol;
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // One 16-bit slice of the second operand per step, lowest slice first.
    always_comb begin
        chunk      = '0;
        pp_shifted = '0;
        unique case (r_k)
            2'd0:    chunk = r_mul_b[15:0];
            2'd1:    chunk = r_mul_b[31:16];
            2'd2:    chunk = r_mul_b[47:32];
            default: chunk = '0;
        endcase
        pp = PP_W'(r_mul_a) * PP_W'(chunk);
        unique case (r_k)
            2'd0:    pp_shifted = {32'd0, pp};
            2'd1:    pp_shifted = {16'd0, pp, 16'd0};
            2'd2:    pp_shifted = {pp, 32'd0};
            default: pp_shifted = '0;
        endcase
    end

    // Round half up, drop the fraction (the square pass keeps the whole product) and clamp to the pass's limit.
    always_comb begin
        sum_rnd = '0;
        q       = '0;
        limit   = POS_MAX;
        unique case (i_cmd.op)
            OP_NORM: begin
                sum_rnd = {1'b0, r_prod} + RND_16;
                q       = sum_rnd >> 16;
                limit   = VOL_MAX;
            end
            OP_VOL: begin
                sum_rnd = {1'b0, r_prod} + RND_32;
                q       = sum_rnd >> 32;
                limit   = VOL_MAX;
            end
            OP_SQ: begin
                sum_rnd = {1'b0, r_prod};
                q       = sum_rnd;
            end
            OP_AMT1: begin
                sum_rnd = {1'b0, r_prod} + RND_16;
                q       = sum_rnd >> 16;
            end
            OP_AMT2: begin
                sum_rnd = {1'b0, r_prod} + RND_32;
                q       = sum_rnd >> 32;
            end
            default: begin
                sum_rnd = '0;
                q       = '0;
            end
        endcase
        rnd_sat = q > SUM_W'(limit);
    end

    // Accumulator update; an entry not written since the last clear reads as zero.
    assign old_valid = comp_in_range && r_valid[addr];
    assign old_acc   = old_valid ? ram_rd[ACC_W-1:0] : '0;
    assign old_mark  = old_valid && ram_rd[ACC_W];
    assign amt       = (r_mode == MODE_VALUE && r_coef[31]) ? (~r_res + 64'd1) : r_res;
    assign acc_sum   = old_acc + amt;
    assign acc_ovf   = (old_acc[63] == amt[63]) && (acc_sum[63] != old_acc[63]);
    assign acc_new   = acc_ovf ? (old_acc[63] ? NEG_MIN : POS_MAX) : acc_sum;

    cia_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.acc_write),
        .i_wr_addr (addr),
        .i_wr_data ({old_mark | r_sat | acc_ovf, acc_new}),
        .i_rd_en   (i_cmd.rd_acc),
        .i_rd_addr (addr),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RST;
            r_num_basis <= NUM_BASIS_RST;
            r_num_comp  <= NUM_COMPONENTS_RST;
            r_vol       <= VOL_ONE;
            r_valid     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MODE:           r_mode      <= i_cfg_data[1:0];
                    CFG_NUM_BASIS:      r_num_basis <= i_cfg_data[5:0];
                    CFG_NUM_COMPONENTS: r_num_comp  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.vol_set) begin
                r_vol <= r_res[47:0];
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.acc_write) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_cmd.mul_start) begin
                r_k <= '0;
            end else if (i_cmd.mul_step) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= i_kind;
            r_dim   <= i_dim_index;
            r_width <= i_width;
            r_comp  <= i_component;
            r_basis <= i_basis_index;
            r_coef  <= i_coefficient;
        end
        if (i_cmd.load_wshift) begin
            r_res <= 64'(w_shift);
            r_sat <= 1'b0;
        end else if (i_cmd.round) begin
            r_res <= rnd_sat ? limit : q[63:0];
            r_sat <= rnd_sat;
        end
        if (i_cmd.mul_start) begin
            r_mul_a <= n_mul_a;
            r_mul_b <= n_mul_b;
            r_prod  <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= r_prod + pp_shifted;
        end
        if (i_cmd.out_load) begin
            r_out_comp  <= r_comp;
            r_out_total <= old_acc;
            r_out_sat   <= old_mark;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_component = r_out_comp;
    assign o_total          = r_out_total;
    assign o_saturated      = r_out_sat;

endmodule

`default_nettype wire

FILE: hw/rtl/cell_integral_accumulator.sv
`default_nettype none

// Cell integral accumulator. Width beats build a Q16.32 cell volume (dimension 0 restarts it),
// coefficient beats add value, magnitude or square times the volume into a saturating Q32.32
// accumulator per component, read beats return one accumulator with its saturation mark, and
// clear beats zero every accumulator while keeping the volume. Items are handled one at a time:
// a clear is decoded and done; a read also waits, if need be, for the result register to drain; a
// width that needs no multiply goes straight to the volume update; a single product (a coefficient
// in value or absolute mode, or a width needing one multiply) loads, steps and rounds the
// multiplier, then stores the result; a normalised width for a higher dimension or a coefficient in
// square mode runs two such products. One shared 64 by 16 bit multiplier takes three steps per
// product, followed by a rounding step, with the accumulator held in a small RAM that is read and
// then written back. A result waiting in the output register does not stop the block taking
// further width, coefficient or clear items, but a further read waits until that register has drained.
module cell_integral_accumulator import cia_pkg::*; #(
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    cia_in_if.sink                 i_item,
    cia_out_if.source              o_result,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_item.ready = in_ready;

    cia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cia_datapath #(
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_item.kind),
        .i_dim_index      (i_item.dim_index),
        .i_width          (i_item.width),
        .i_component      (i_item.component),
        .i_basis_index    (i_item.basis_index),
        .i_coefficient    (i_item.coefficient),
        .o_out_valid      (o_result.valid),
        .i_out_ready      (o_result.ready),
        .o_read_component (o_result.read_component),
        .o_total          (o_result.total),
        .o_saturated      (o_result.saturated),
        .i_cmd            (cmd),
        .o_status         (status)
    );

    // An accepted item always keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted on two consecutive cycles");

    // A result only appears after the controller has loaded a read.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(cmd.out_load))
        else $error("result valid without a read being loaded");

    // Only a coefficient that passed every range check reaches its accumulator.
    a_acc_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.acc_write |-> (status.coef_ok && status.kind == KIND_COEF))
        else $error("accumulator written for an ignored item");

    // The multiplier never runs while the block is waiting for a new item.
    a_no_mul_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !(cmd.mul_step || cmd.mul_start))
        else $error("multiplier active while ready for input");

endmodule

`default_nettype wire

FILE: bench/cell_integral_accumulator_test.sv
`default_nettype none

module cell_integral_accumulator_test;
    import cia_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SEGMENT_ITEMS  = 50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  dim;
        logic [31:0] width;
        logic [2:0]  comp;
        logic [4:0]  basis;
        logic [31:0] coef;
    } t_grid_item;

    typedef struct packed {
        logic [2:0]  comp;
        logic [63:0] total;
        logic        sat;
    } t_integral;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    cia_in_if  item_if ();
    cia_out_if result_if ();

    cell_integral_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: configuration, cell volume, accumulators and marks.
    logic [1:0]  mode_r;
    logic [5:0]  basis_count;
    logic [3:0]  comp_count;
    logic [47:0] vol_q;
    logic [63:0] acc_q [MAX_COMPONENTS_DEF];
    logic        mark_q [MAX_COMPONENTS_DEF];

    t_integral expected_totals [$];
    int        mismatches;
    int        items_sent;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int unsigned s,
                                                   input logic [63:0] limit,
                                                   output logic clamped);
        logic [128:0] prod;
        logic [128:0] q;
        prod = {65'd0, a} * {65'd0, b};
        prod = prod + (129'd1 << (s - 1));
        q = prod >> s;
        clamped = (q > {65'd0, limit});
        return clamped ? limit : q[63:0];
    endfunction

    task automatic clear_totals();
        for (int i = 0; i < MAX_COMPONENTS_DEF; i++) begin
            acc_q[i]  = 64'd0;
            mark_q[i] = 1'b0;
        end
    endtask

    task automatic integrate_item(input t_grid_item it);
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] mag;
        logic [63:0] amount;
        logic [63:0] acc;
        logic [63:0] sum;
        logic        hit;
        logic        neg;
        t_integral   rd;
        hit = 1'b0;
        case (it.kind)
            KIND_WIDTH: begin
                if (it.dim < MAX_DIMS) begin
                    if (basis_count <= 6'd1) begin
                        w = {16'd0, it.width, 16'd0};
                    end else if (mode_r <= MODE_ABS) begin
                        t = {32'd0, it.width} * {32'd0, INV_SQRT2_Q32};
                        w = (t + 64'd32768) >> 16;
                    end else begin
                        w = {17'd0, it.width, 15'd0};
                    end
                    if (it.dim == 3'd0) begin
                        vol_q = w[47:0];
                    end else begin
                        t = scaled_product({16'd0, vol_q}, w, 32, VOL_MAX, hit);
                        vol_q = t[47:0];
                    end
                end
            end
            KIND_COEF: begin
                neg = it.coef[31];
                mag = neg ? {32'd0, (~it.coef + 32'd1)} : {32'd0, it.coef};
                if ({1'b0, it.comp} < comp_count && it.comp < MAX_COMPONENTS_DEF &&
                    {1'b0, it.basis} < basis_count && it.basis < MAX_BASIS &&
                    mode_r != MODE_RESERVED &&
                    (mode_r == MODE_SQUARE || it.basis == 5'd0)) begin
                    if (mode_r <= MODE_ABS) begin
                        amount = scaled_product(mag, {16'd0, vol_q}, 16, POS_MAX, hit);
                        if (mode_r == MODE_VALUE && neg) amount = -amount;
                    end else begin
                        amount = scaled_product(mag * mag, {16'd0, vol_q}, 32, POS_MAX, hit);
                    end
                    if (hit) mark_q[it.comp] = 1'b1;
                    acc = acc_q[it.comp];
                    sum = acc + amount;
                    // Overflow only when both operands share a sign the sum lost.
                    if (acc[63] == amount[63] && sum[63] != acc[63]) begin
                        sum = acc[63] ? NEG_MIN : POS_MAX;
                        mark_q[it.comp] = 1'b1;
                    end
                    acc_q[it.comp] = sum;
                end
            end
            KIND_READ: begin
                rd.comp = it.comp;
                if (it.comp < MAX_COMPONENTS_DEF) begin
                    rd.total = acc_q[it.comp];
                    rd.sat   = mark_q[it.comp];
                end else begin
                    rd.total = 64'd0;
                    rd.sat   = 1'b0;
                end
                expected_totals.push_back(rd);
            end
            default: begin
                clear_totals();
            end
        endcase
    endtask

    function automatic t_grid_item random_item();
        t_grid_item it;
        it.kind  = 2'($urandom_range(3));
        it.dim   = 3'($urandom_range(7));
        it.width = $urandom();
        it.comp  = 3'($urandom_range(7));
        it.basis = 5'($urandom_range(31));
        it.coef  = $urandom();
        return it;
    endfunction

    function automatic t_grid_item width_item(input logic [2:0] dim, input logic [31:0] w);
        t_grid_item it;
        it = random_item();
        it.kind  = KIND_WIDTH;
        it.dim   = dim;
        it.width = w;
        return it;
    endfunction

    function automatic t_grid_item coef_item(input logic [2:0] comp, input logic [4:0] basis,
                                             input logic [31:0] coef);
        t_grid_item it;
        it = random_item();
        it.kind  = KIND_COEF;
        it.comp  = comp;
        it.basis = basis;
        it.coef  = coef;
        return it;
    endfunction

    function automatic t_grid_item read_item(input logic [2:0] comp);
        t_grid_item it;
        it = random_item();
        it.kind = KIND_READ;
        it.comp = comp;
        return it;
    endfunction

    function automatic t_grid_item clear_item();
        t_grid_item it;
        it = random_item();
        it.kind = KIND_CLEAR;
        return it;
    endfunction

    // Widths near one cell unit most of the time, so volumes stay in range.
    function automatic logic [31:0] random_width();
        if ($urandom_range(3) == 0) return $urandom();
        return $urandom_range(32'h0000_8000, 32'h0002_0000);
    endfunction

    // Valid stays high from one beat to the next; only a gap or settle lowers it.
    task automatic send_item(input t_grid_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.kind        <= it.kind;
        item_if.dim_index   <= it.dim;
        item_if.width       <= it.width;
        item_if.component   <= it.comp;
        item_if.basis_index <= it.basis;
        item_if.coefficient <= it.coef;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        integrate_item(it);
        items_sent++;
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        while (expected_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [1:0] m, input logic [5:0] nb, input logic [3:0] nc);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= {4'd0, m};
        @(posedge i_clk);
        mode_r = m;
        i_cfg_index <= CFG_NUM_BASIS;
        i_cfg_data  <= nb;
        @(posedge i_clk);
        basis_count = nb;
        i_cfg_index <= CFG_NUM_COMPONENTS;
        i_cfg_data  <= {2'd0, nc};
        @(posedge i_clk);
        comp_count = nc;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_item(read_item(3'd0));
        send_item(coef_item(3'd0, 5'd0, 32'h0001_8000));
        // Only one component is live straight after reset.
        send_item(coef_item(3'd1, 5'd0, 32'h0001_0000));
        send_item(read_item(3'd0));
    endtask

    task automatic test_value_extremes();
        settle();
        load_config(MODE_VALUE, 6'd1, 4'd8);
        send_item(width_item(3'd0, 32'hFFFF_FFFF));
        send_item(width_item(3'd5, 32'hFFFF_FFFF));
        send_item(width_item(3'd6, 32'h0000_0000));
        send_item(coef_item(3'd1, 5'd0, 32'h7FFF_FFFF));
        send_item(coef_item(3'd2, 5'd0, 32'h8000_0000));
        send_item(read_item(3'd1));
        send_item(read_item(3'd2));
        send_item(clear_item());
        send_item(read_item(3'd2));
    endtask

    task automatic test_normalised_width();
        settle();
        load_config(MODE_ABS, 6'd2, 4'd3);
        send_item(width_item(3'd0, 32'h0002_0000));
        send_item(width_item(3'd3, 32'h0001_8000));
        send_item(coef_item(3'd0, 5'd1, 32'h0123_4567));
        send_item(coef_item(3'd0, 5'd0, 32'h8000_0000));
        send_item(coef_item(3'd3, 5'd0, 32'h0001_0000));
        send_item(read_item(3'd0));
        send_item(read_item(3'd3));
    endtask

    task automatic test_square_and_unused_mode();
        settle();
        load_config(MODE_SQUARE, 6'd32, 4'd8);
        send_item(width_item(3'd0, 32'h0001_0000));
        send_item(coef_item(3'd7, 5'd31, 32'h8000_0000));
        send_item(read_item(3'd7));
        settle();
        // A zero basis count behaves like one: widths are taken unscaled.
        load_config(MODE_RESERVED, 6'd0, 4'd15);
        send_item(width_item(3'd1, 32'hFFFF_FFFF));
        send_item(coef_item(3'd7, 5'd0, 32'h0000_0001));
        send_item(read_item(3'd7));
    endtask

    task automatic test_output_backpressure();
        settle();
        load_config(MODE_VALUE, 6'd1, 4'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if (i % 3 == 0) send_item(read_item(3'(i % 8)));
            else send_item(coef_item(3'(i % 8), 5'd0, $urandom()));
        end
    endtask

    task automatic test_random_cells();
        int          start;
        int          lim_c;
        int          lim_b;
        int          dims;
        logic [1:0]  m;
        logic [5:0]  nb;
        logic [3:0]  nc;
        logic [2:0]  comp;
        logic [4:0]  basis;
        logic [31:0] coef;
        for (int seg = 0; seg < 8; seg++) begin
            settle();
            m = ($urandom_range(7) == 0) ? MODE_RESERVED : 2'($urandom_range(2));
            case ($urandom_range(5))
                0: nb = 6'd1;
                1: nb = 6'd32;
                2: nb = 6'($urandom_range(63));
                default: nb = 6'($urandom_range(2, 32));
            endcase
            nc = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
            load_config(m, nb, nc);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            lim_c = (nc > 4'd8) ? 8 : int'(nc);
            lim_b = (nb > 6'd32) ? 32 : int'(nb);
            start = items_sent;
            while (items_sent - start < SEGMENT_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    send_item(random_item());
                end else begin
                    // One cell: volume first, then its coefficients, then maybe a read and maybe a clear.
                    send_item(width_item(3'd0, random_width()));
                    dims = $urandom_range(5);
                    for (int d = 1; d <= dims; d++) send_item(width_item(3'(d), random_width()));
                    repeat ($urandom_range(1, 6)) begin
                        if (lim_c > 0 && $urandom_range(9) != 0)
                            comp = 3'($urandom_range(lim_c - 1));
                        else
                            comp = 3'($urandom_range(7));
                        if (m <= MODE_ABS && $urandom_range(4) != 0)
                            basis = 5'd0;
                        else if (lim_b > 0 && $urandom_range(9) != 0)
                            basis = 5'($urandom_range(lim_b - 1));
                        else
                            basis = 5'($urandom_range(31));
                        if ($urandom_range(1) == 0) begin
                            coef = $urandom();
                        end else begin
                            coef = $urandom_range(32'h0004_0000);
                            if ($urandom_range(1) == 1) coef = -coef;
                        end
                        send_item(coef_item(comp, basis, coef));
                    end
                    if ($urandom_range(1) == 1) send_item(read_item(3'($urandom_range(7))));
                    if ($urandom_range(19) == 0) send_item(clear_item());
                end
            end
        end
    endtask

    initial begin : result_sink
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    result_if.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_integral want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (expected_totals.size() == 0) begin
                mismatches++;
                $display("%0t: result beat expected none, got component %0d total %h",
                         $time, result_if.read_component, result_if.total);
            end else begin
                want = expected_totals.pop_front();
                if (result_if.read_component !== want.comp) begin
                    mismatches++;
                    $display("%0t: read_component expected %0d, got %0d",
                             $time, want.comp, result_if.read_component);
                end
                if (result_if.total !== want.total) begin
                    mismatches++;
                    $display("%0t: total of component %0d expected %h, got %h",
                             $time, want.comp, want.total, result_if.total);
                end
                if (result_if.saturated !== want.sat) begin
                    mismatches++;
                    $display("%0t: saturated of component %0d expected %b, got %b",
                             $time, want.comp, want.sat, result_if.saturated);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_index         <= CFG_MODE;
        i_cfg_data          <= '0;
        item_if.valid       <= 1'b0;
        item_if.kind        <= KIND_WIDTH;
        item_if.dim_index   <= '0;
        item_if.width       <= '0;
        item_if.component   <= '0;
        item_if.basis_index <= '0;
        item_if.coefficient <= '0;
        mismatches     = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        mode_r         = MODE_RST;
        basis_count    = NUM_BASIS_RST;
        comp_count     = NUM_COMPONENTS_RST;
        vol_q          = VOL_ONE;
        clear_totals();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_value_extremes();
        test_normalised_width();
        test_square_and_unused_mode();
        test_output_backpressure();
        test_random_cells();
        settle();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/cia_pkg.sv
hw/rtl/cia_in_if.sv
hw/rtl/cia_out_if.sv
hw/rtl/cia_ram.sv
hw/rtl/cia_ctrl.sv
hw/rtl/cia_datapath.sv
hw/rtl/cell_integral_accumulator.sv
bench/cell_integral_accumulator_test.sv
